[hw/rtl/ksm_pkg.sv]
// Shared types and codes for the k-way sorted merge block.
// Used by ksm_store and by k_way_sorted_merge; depends on nothing else.
`timescale 1ns / 1ps

package ksm_pkg;

  typedef logic signed [31:0] data_t;

  // Command codes of an input request.
  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  // Status codes of a result.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_DROP  = 2'd2;

  typedef struct packed {
    logic        command;
    logic [2:0]  seq_index;
    data_t       value;
  } in_t;

  typedef struct packed {
    data_t       out_value;
    logic [1:0]  status;
  } out_t;

endpackage

[hw/rtl/ksm_store.sv]
// Element store of the sorted merge block: one write port, one registered read port.
// Depends on ksm_pkg for the element type.
`timescale 1ns / 1ps

module ksm_store #(
  parameter int unsigned ADDR_W = 9,
  parameter int unsigned DEPTH  = 512
) (
  input  logic                  clk_i,
  input  logic                  wr_en_i,
  input  logic [ADDR_W-1:0]     wr_addr_i,
  input  ksm_pkg::data_t        wr_data_i,
  input  logic                  rd_en_i,
  input  logic [ADDR_W-1:0]     rd_addr_i,
  output ksm_pkg::data_t        rd_data_o
);
  import ksm_pkg::*;

  data_t mem_q [DEPTH];
  data_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[hw/rtl/k_way_sorted_merge.sv]
// K-way sorted merge: per-sequence FIFOs in a shared store, pops return the smallest head.
// An append runs through S_APPEND and a pop through S_SCAN and S_ADVANCE, both ending in S_DONE;
// the head scan reads one head a cycle through the single store read port.
// One request is handled at a time: the next is taken only after the last has left S_DONE;
// a result blocked at the output register holds the block until it drains.
// Reset (rst_ni, asynchronous, active low) empties every sequence; the store is not cleared.
`timescale 1ns / 1ps

module k_way_sorted_merge #(
  parameter int unsigned NUM_SEQS  = 8,
  parameter int unsigned SEQ_DEPTH = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ksm_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ksm_pkg::out_t out_o
);
  import ksm_pkg::*;

  localparam int unsigned IDX_W  = $clog2(NUM_SEQS);
  localparam int unsigned CNT_W  = $clog2(NUM_SEQS + 1);
  localparam int unsigned SLOT_W = $clog2(SEQ_DEPTH);
  localparam int unsigned FILL_W = $clog2(SEQ_DEPTH + 1);
  localparam int unsigned ADDR_W = IDX_W + SLOT_W;
  localparam int unsigned MEM_DEPTH = NUM_SEQS * (2 ** SLOT_W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPEND,
    S_SCAN,
    S_ADVANCE,
    S_DONE
  } state_e;

  state_e              state_q;
  logic [IDX_W-1:0]    idx_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                sel_ok_q;
  data_t               val_q;
  logic [SLOT_W-1:0]   head_q [NUM_SEQS];
  logic [FILL_W-1:0]   fill_q [NUM_SEQS];
  logic                found_q;
  data_t               best_val_q;
  logic                cmp_v_q;
  logic [IDX_W-1:0]    cmp_idx_q;
  logic                nonempty_q;
  out_t                res_q;
  out_t                out_q;
  logic                out_valid_q;

  logic                scan_live;
  logic [IDX_W-1:0]    scan_idx;
  logic [IDX_W-1:0]    rd_idx;
  logic [SLOT_W-1:0]   cur_head;
  logic [FILL_W-1:0]   cur_fill;
  logic [SLOT_W:0]     slot_sum;
  logic [SLOT_W-1:0]   wr_slot;
  logic [SLOT_W-1:0]   head_next;
  logic                full;
  logic                wr_en;
  logic                rd_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [ADDR_W-1:0]   rd_addr;
  data_t               rd_data;
  logic                lower;
  logic                load_out;

  // The scan steps one sequence a cycle; otherwise the working index selects the sequence.
  assign scan_live = (cnt_q < CNT_W'(NUM_SEQS));
  assign scan_idx  = scan_live ? cnt_q[IDX_W-1:0] : '0;
  assign rd_idx    = (state_q == S_SCAN) ? scan_idx : idx_q;
  assign cur_head  = head_q[rd_idx];
  assign cur_fill  = fill_q[rd_idx];

  // Tail slot wraps with a single compare and subtract, since head stays below the depth and fill never exceeds it.
  assign slot_sum  = {1'b0, cur_head} + (SLOT_W + 1)'(cur_fill);
  assign wr_slot   = (slot_sum >= (SLOT_W + 1)'(SEQ_DEPTH)) ?
                     SLOT_W'(slot_sum - (SLOT_W + 1)'(SEQ_DEPTH)) : slot_sum[SLOT_W-1:0];
  assign head_next = (cur_head == SLOT_W'(SEQ_DEPTH - 1)) ? '0 : cur_head + SLOT_W'(1);
  assign full      = (cur_fill == FILL_W'(SEQ_DEPTH));

  assign wr_en   = (state_q == S_APPEND) && sel_ok_q && !full;
  assign wr_addr = {idx_q, wr_slot};
  assign rd_en   = (state_q == S_SCAN) && scan_live;
  assign rd_addr = {scan_idx, cur_head};

  // Shared comparator: a strict less-than keeps the lowest-numbered sequence on a tie.
  assign lower = !found_q || (rd_data < best_val_q);

  // A finished result moves to the output register once that register is free or draining.
  assign load_out = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  ksm_store #(
    .ADDR_W (ADDR_W),
    .DEPTH  (MEM_DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (val_q),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      cnt_q       <= '0;
      sel_ok_q    <= 1'b0;
      val_q       <= '0;
      found_q     <= 1'b0;
      best_val_q  <= '0;
      cmp_v_q     <= 1'b0;
      cmp_idx_q   <= '0;
      nonempty_q  <= 1'b0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_SEQS; i++) begin
        head_q[i] <= '0;
        fill_q[i] <= '0;
      end
    end else begin
      if (load_out) begin
        out_q       <= res_q;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            idx_q    <= IDX_W'(in_i.seq_index);
            sel_ok_q <= (32'(in_i.seq_index) < NUM_SEQS);
            val_q    <= in_i.value;
            cnt_q    <= '0;
            found_q  <= 1'b0;
            cmp_v_q  <= 1'b0;
            state_q  <= (in_i.command == CMD_POP) ? S_SCAN : S_APPEND;
          end
        end
        S_APPEND: begin
          if (!sel_ok_q || full) begin
            res_q <= '{out_value: '0, status: ST_DROP};
          end else begin
            fill_q[idx_q] <= cur_fill + FILL_W'(1);
            res_q         <= '{out_value: '0, status: ST_OK};
          end
          state_q <= S_DONE;
        end
        S_SCAN: begin
          // Reads are issued in the cycle before the compare that consumes them.
          if (rd_en) begin
            nonempty_q <= (cur_fill != '0);
            cmp_idx_q  <= scan_idx;
            cnt_q      <= cnt_q + CNT_W'(1);
          end
          cmp_v_q <= rd_en;
          if (cmp_v_q && nonempty_q && lower) begin
            found_q    <= 1'b1;
            best_val_q <= rd_data;
            idx_q      <= cmp_idx_q;
          end
          if (!rd_en) begin
            state_q <= S_ADVANCE;
          end
        end
        S_ADVANCE: begin
          if (found_q) begin
            head_q[idx_q] <= head_next;
            fill_q[idx_q] <= cur_fill - FILL_W'(1);
            res_q         <= '{out_value: best_val_q, status: ST_OK};
          end else begin
            res_q <= '{out_value: '0, status: ST_EMPTY};
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (load_out) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef NO_ASSERTIONS
  // A request that has been taken keeps the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("block ready again right after taking a request");

  // Any result whose status is not OK carries a zero value.
  a_zero_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.status != ST_OK) |-> (out_o.out_value == '0))
    else $error("failed request returned a non-zero value");

  // The store is written only by an append that was found to have room.
  a_write_in_append: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == S_APPEND) && (cur_fill < FILL_W'(SEQ_DEPTH)))
    else $error("store written outside an accepted append");

  // The winning sequence of a scan is never an empty one.
  a_winner_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ADVANCE) && found_q |-> (cur_fill != '0))
    else $error("pop advanced an empty sequence");
`endif

endmodule
